// ===== hdl/brau_pkg.sv =====
// Shared types and codes for the bitmap run allocator.
`timescale 1ns / 1ps
package brau_pkg;
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ZERO    = 2'd1,
        STATUS_NOSPACE = 2'd2
    } status_t;

    localparam int REQ_W     = 20;
    localparam int ADDR_W    = 32;
    localparam int AREA_W    = 9;
    localparam int AREA_RST  = 256;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_BYTES   = 8'd1;
endpackage

// ===== hdl/bitmap_run_allocator_unit.sv =====
// Top level of the first-fit bitmap run allocator.
//
// Requests arrive on the s_ stream: tdata holds request_bytes (20 bits, zero
// padded to 24). Each request yields exactly one result on the m_ stream:
// tdata holds status (bits 1:0) and address (bits 33:2), padded to 40 bits.
// The cfg_ channel writes base_address (index 0) or area_bytes (index 1);
// other indexes are ignored. Write configuration only while idle.
// One request is handled at a time; a zero-size request skips the map.
// Otherwise the occupancy map memory is scanned byte by byte (read, then
// check eight blocks) over at most area_bytes bytes (capped at MAP_BYTES);
// a hit then rewrites each touched byte (read, then set the run's bits).
// After reset a clearing pass zeroes all MAP_BYTES map bytes; s_tready
// stays low during it. A result waits in the output register while the
// receiver stalls; the next request is not taken until that result leaves.
`timescale 1ns / 1ps
module bitmap_run_allocator_unit #(
    parameter int MAP_BYTES   = 256,
    parameter int BLOCK_SHIFT = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // request_bytes[19:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], address[33:2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [brau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [brau_pkg::CFG_DAT_W-1:0] cfg_data
);
    localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int NW0  = $clog2(MAP_BYTES + 1);
    localparam int NW   = (NW0 > brau_pkg::AREA_W) ? NW0 : brau_pkg::AREA_W;
    localparam int BW   = AW + 3;
    localparam int CW   = brau_pkg::REQ_W - BLOCK_SHIFT;
    localparam int SW   = (BW > CW) ? BW : CW;

    typedef enum logic [2:0] {
        ST_CLR, ST_IDLE, ST_SREAD, ST_SCHK, ST_WREAD, ST_WMOD, ST_FIN
    } state_t;

    state_t                  state_reg;
    logic [NW-1:0]           idx_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           run_reg;
    logic [BW-1:0]           start_reg;
    logic [BW-1:0]           end_reg;
    logic [31:0]             base_reg;
    logic [brau_pkg::AREA_W-1:0] area_reg;
    brau_pkg::status_t       res_status_reg;
    logic                    out_valid_reg;
    brau_pkg::status_t       out_status_reg;
    logic [31:0]             out_addr_reg;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [7:0]              wr_data;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rd_data;

    logic [NW-1:0]           lim;
    logic [CW-1:0]           run_next;
    logic                    hit;
    logic [BW-1:0]           hit_end;
    logic [7:0]              mask;
    logic [CW-1:0]           req_count;
    logic [SW-1:0]           start_wide;

    brau_ram #(.WIDTH(8), .DEPTH(MAP_BYTES), .AW(AW)) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_addr_reg, out_status_reg};
    assign req_count = s_tdata[brau_pkg::REQ_W-1:BLOCK_SHIFT];

    always_comb begin
        if (NW'(area_reg) > NW'(MAP_BYTES)) begin
            lim = NW'(MAP_BYTES);
        end else begin
            lim = NW'(area_reg);
        end
    end

    // scan eight blocks of the current byte, lowest block in the MSB
    always_comb begin
        logic [CW-1:0] r;
        logic          h;
        logic [BW-1:0] e;
        r = run_reg;
        h = 1'b0;
        e = end_reg;
        for (int k = 0; k < 8; k++) begin
            if (!h) begin
                if (rd_data[7-k]) begin
                    r = '0;
                end else begin
                    r = r + CW'(1);
                    if (r == count_reg) begin
                        h = 1'b1;
                        e = {idx_reg[AW-1:0], 3'(k)};
                    end
                end
            end
        end
        run_next = r;
        hit      = h;
        hit_end  = e;
    end

    assign start_wide = SW'(hit_end) + SW'(1) - SW'(count_reg);

    always_comb begin
        logic [BW-1:0] blk;
        blk  = '0;
        mask = '0;
        for (int k = 0; k < 8; k++) begin
            blk = {idx_reg[AW-1:0], 3'(k)};
            mask[7-k] = (blk >= start_reg) && (blk <= end_reg);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = 8'd0;
        rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_CLR: begin
                wr_en = 1'b1;
            end
            ST_WMOD: begin
                wr_en   = 1'b1;
                wr_data = rd_data | mask;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            run_reg       <= '0;
            base_reg      <= '0;
            area_reg      <= brau_pkg::AREA_W'(brau_pkg::AREA_RST);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == brau_pkg::REG_BASE_ADDRESS) begin
                    base_reg <= cfg_data;
                end else if (cfg_index == brau_pkg::REG_AREA_BYTES) begin
                    area_reg <= cfg_data[brau_pkg::AREA_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR: begin
                    if (idx_reg == NW'(MAP_BYTES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                    idx_reg <= idx_reg + NW'(1);
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        count_reg <= req_count;
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        if (req_count == '0) begin
                            res_status_reg <= brau_pkg::STATUS_ZERO;
                            state_reg      <= ST_FIN;
                        end else begin
                            state_reg <= ST_SREAD;
                        end
                    end
                end
                ST_SREAD: begin
                    if (idx_reg >= lim) begin
                        res_status_reg <= brau_pkg::STATUS_NOSPACE;
                        state_reg      <= ST_FIN;
                    end else begin
                        state_reg <= ST_SCHK;
                    end
                end
                ST_SCHK: begin
                    run_reg <= run_next;
                    if (hit) begin
                        end_reg   <= hit_end;
                        start_reg <= start_wide[BW-1:0];
                        idx_reg   <= NW'(start_wide[BW-1:3]);
                        state_reg <= ST_WREAD;
                    end else begin
                        idx_reg   <= idx_reg + NW'(1);
                        state_reg <= ST_SREAD;
                    end
                end
                ST_WREAD: begin
                    state_reg <= ST_WMOD;
                end
                ST_WMOD: begin
                    if (idx_reg[AW-1:0] == end_reg[BW-1:3]) begin
                        res_status_reg <= brau_pkg::STATUS_OK;
                        state_reg      <= ST_FIN;
                    end else begin
                        idx_reg   <= idx_reg + NW'(1);
                        state_reg <= ST_WREAD;
                    end
                end
                ST_FIN: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        if (res_status_reg == brau_pkg::STATUS_OK) begin
                            out_addr_reg <= base_reg
                                + 32'(64'(start_reg) << BLOCK_SHIFT);
                        end else begin
                            out_addr_reg <= '0;
                        end
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_err_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status_reg != brau_pkg::STATUS_OK) |-> out_addr_reg == '0)
        else $error("error result carries a non-zero address");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_tready)
        else $error("request taken during clearing pass");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WMOD) |-> (idx_reg[AW-1:0] >= start_reg[BW-1:3])
            && (idx_reg[AW-1:0] <= end_reg[BW-1:3]))
        else $error("map write outside the allocated run");

    a_fin_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && (!out_valid_reg || m_tready) |=> m_tvalid)
        else $error("finished result not presented");
endmodule

// ===== hdl/brau_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module brau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== sim/bitmap_run_allocator_unit_test.sv =====
// Self-checking testbench for the first-fit bitmap run allocator.
`timescale 1ns / 1ps
module bitmap_run_allocator_unit_test;
    localparam int MAP_BYTES   = 256;
    localparam int BLOCK_SHIFT = 6;
    localparam int STALL_LIMIT = 50000;
    localparam logic [brau_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    typedef struct packed {
        brau_pkg::status_t           status;
        logic [brau_pkg::ADDR_W-1:0] address;
    } grant_t;

    class alloc_scoreboard;
        bit [MAP_BYTES*8-1:0]        taken;
        logic [brau_pkg::ADDR_W-1:0] base;
        logic [brau_pkg::AREA_W-1:0] area;
        grant_t                      grants[$];
        int                          mismatches;

        function new();
            taken      = '0;
            base       = '0;
            area       = brau_pkg::AREA_W'(brau_pkg::AREA_RST);
            mismatches = 0;
        endfunction

        function void write_reg(logic [brau_pkg::CFG_IDX_W-1:0] idx,
                                logic [brau_pkg::CFG_DAT_W-1:0] val);
            if (idx == brau_pkg::REG_BASE_ADDRESS) base = val;
            else if (idx == brau_pkg::REG_AREA_BYTES) area = val[brau_pkg::AREA_W-1:0];
        endfunction

        function void note_request(logic [brau_pkg::REQ_W-1:0] req);
            int     count;
            int     blocks;
            int     run;
            int     start;
            grant_t g;
            count    = req >> BLOCK_SHIFT;
            blocks   = ((area > MAP_BYTES) ? MAP_BYTES : area) * 8;
            run      = 0;
            g.status = brau_pkg::STATUS_NOSPACE;
            g.address = '0;
            if (count == 0) begin
                g.status = brau_pkg::STATUS_ZERO;
            end else begin
                for (int b = 0; b < blocks; b++) begin
                    if (taken[b]) begin
                        run = 0;
                        continue;
                    end
                    run++;
                    if (run == count) begin
                        start = b + 1 - count;
                        for (int k = start; k <= b; k++) taken[k] = 1'b1;
                        g.status  = brau_pkg::STATUS_OK;
                        g.address = base + (brau_pkg::ADDR_W'(start) << BLOCK_SHIFT);
                        break;
                    end
                end
            end
            grants.push_back(g);
        endfunction

        function void check_grant(logic [39:0] data);
            grant_t                      want;
            brau_pkg::status_t           got_status;
            logic [brau_pkg::ADDR_W-1:0] got_addr;
            got_status = brau_pkg::status_t'(data[1:0]);
            got_addr   = data[33:2];
            if (grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d address %h",
                             got_status, got_addr);
                return;
            end
            want = grants.pop_front();
            if (got_status !== want.status || got_addr !== want.address
                    || data[39:34] !== 6'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d address %h, got status %0d address %h",
                             want.status, want.address, got_status, got_addr);
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [39:0]                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [brau_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [brau_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    alloc_scoreboard sb = new();
    bit              calm = 1'b0;
    int              quiet_cycles = 0;

    bitmap_run_allocator_unit #(.MAP_BYTES(MAP_BYTES), .BLOCK_SHIFT(BLOCK_SHIFT)) uut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_grant(m_tdata);
            m_tready <= calm || ($urandom_range(99) >= 28);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(logic [brau_pkg::REQ_W-1:0] req);
        int gap;
        gap = (!calm && $urandom_range(99) < 28) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req);
    endtask

    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (sb.grants.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [brau_pkg::CFG_IDX_W-1:0] idx,
                             logic [brau_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [brau_pkg::REQ_W-1:0] random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return brau_pkg::REQ_W'($urandom_range(63));
        if (pick < 20) return brau_pkg::REQ_W'($urandom);
        if (pick < 30)
            return brau_pkg::REQ_W'(($urandom_range(4, 40) << BLOCK_SHIFT) | $urandom_range(63));
        return brau_pkg::REQ_W'(($urandom_range(1, 3) << BLOCK_SHIFT) | $urandom_range(63));
    endfunction

    initial begin
        logic [brau_pkg::AREA_W-1:0] areas[6] = '{9'd16, 9'd64, 9'd300, 9'd256, 9'd511, 9'd128};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero size, largest field, smallest run
        send_request(20'd0);
        send_request(20'd63);
        send_request(20'hFFFFF);
        send_request(20'd64);
        send_request(20'd127);
        send_request(20'd5 << BLOCK_SHIFT);
        drain();

        // runs that pass the area end, then one block in a narrow area
        write_reg(brau_pkg::REG_AREA_BYTES, 32'd2);
        write_reg(brau_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFC0);
        send_request(20'd11 << BLOCK_SHIFT);
        send_request(20'd10 << BLOCK_SHIFT);
        send_request(20'd1 << BLOCK_SHIFT);
        drain();

        write_reg(brau_pkg::REG_AREA_BYTES, 32'd0);
        send_request(20'd64);
        send_request(20'd0);
        drain();

        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        write_reg(brau_pkg::REG_AREA_BYTES, 32'h0000_01FF);
        write_reg(brau_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        send_request(20'd2 << BLOCK_SHIFT);
        send_request(20'd2048 << BLOCK_SHIFT);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(brau_pkg::REG_AREA_BYTES, {23'd0, areas[ph]});
            write_reg(brau_pkg::REG_BASE_ADDRESS, (ph == 3) ? 32'd0 : $urandom);
            for (int i = 0; i < 200; i++) begin
                calm = (ph == 2 && i >= 50 && i < 150);
                send_request(random_request());
            end
            calm = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.grants.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== bitmap_run_allocator_unit.f =====
hdl/brau_pkg.sv
hdl/brau_ram.sv
hdl/bitmap_run_allocator_unit.sv
sim/bitmap_run_allocator_unit_test.sv
